### design/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int WORD_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int DEQ_DEPTH = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_t;

  // Per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR
  } cell_op_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] value;
  } cell_link_t;

endpackage

### design/deq_if.sv
`timescale 1ns / 1ps

interface deq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface deq_out_if #(
  parameter int CNT_W = 5
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;

  modport source (output valid, output status, output popped_value, output count,
                  output front_value, output rear_value, input ready);
  modport sink   (input valid, input status, input popped_value, input count,
                  input front_value, input rear_value, output ready);
endinterface

### design/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  deq_pkg::cell_op_t             op,
  input  logic [deq_pkg::WORD_W-1:0]    push_value,
  input  deq_pkg::cell_link_t           left,
  input  deq_pkg::cell_link_t           right,
  output deq_pkg::cell_link_t           cur,
  output logic                          is_rear
);
  import deq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] value_r, value_nxt;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    case (op)
      OP_PUSH_FRONT: begin
        valid_nxt = left.valid;
        value_nxt = left.value;
      end
      OP_POP_FRONT: begin
        valid_nxt = right.valid;
        value_nxt = right.value;
      end
      OP_PUSH_REAR: begin
        // first empty cell behind a held one takes the word
        if (!valid_r && left.valid) begin
          valid_nxt = 1'b1;
          value_nxt = push_value;
        end
      end
      OP_POP_REAR: begin
        if (valid_r && !right.valid) valid_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign cur.valid = valid_r;
  assign cur.value = value_r;
  assign is_rear   = valid_r & ~right.valid;

endmodule

### design/double_ended_queue_top.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words, up to DEPTH entries.
// in_ch  : one item = action (push front/rear, pop front/rear) + push_value.
// out_ch : one result item per input item, in order: status, popped word,
//          count after the item, and the words now at front and rear
//          (0 when empty). Full push / empty pop return a refusal status
//          and leave the queue untouched.
// Storage is a row of DEPTH identical cells; cell 0 is the front. Every
// cycle each cell loads from its left neighbor (push front), its right
// neighbor (pop front), the input word (push rear, first free cell), is
// cleared (pop rear, rear cell), or holds. Rear is the held cell whose
// right neighbor is empty. Cells update at the accept edge; the result
// waits in the pending slot, then is registered in the output register.
// Throughput: 1 item per cycle sustained while out_ch.ready stays high;
// set by the single pending result slot ahead of the output register.
// Stall: while out_ch.ready is low, one finished result waits in the output
// register and one more in the pending slot; in_ch.ready then drops.
// Reset (rst_n low, synchronous): queue empty, no result pending or valid.
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  deq_in_if.sink         in_ch,
  deq_out_if.source      out_ch
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_link_t        cell_q   [DEPTH];
  cell_link_t        cell_l   [DEPTH];
  cell_link_t        cell_r   [DEPTH];
  logic              is_rear  [DEPTH];
  cell_op_t          op;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pending_r;
  stat_t             pend_status_r, status_c;
  logic [WORD_W-1:0] pend_popped_r, popped_c;

  logic              out_valid_r;
  stat_t             out_status_r;
  logic [WORD_W-1:0] out_popped_r, out_front_r, out_rear_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              accept, out_load, full, empty;
  logic [WORD_W-1:0] rear_word, front_word;

  // ---- cell row ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_l[i] = '{valid: 1'b1, value: in_ch.push_value};
    end else begin : g_mid
      assign cell_l[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign cell_r[i] = '{valid: 1'b0, value: '0};
    end else begin : g_next
      assign cell_r[i] = cell_q[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .push_value (in_ch.push_value),
      .left       (cell_l[i]),
      .right      (cell_r[i]),
      .cur        (cell_q[i]),
      .is_rear    (is_rear[i])
    );
  end

  // Exactly one cell flags rear when non-empty; OR of gated words
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | (is_rear[i] ? cell_q[i].value : '0);
    end
  end

  assign front_word = cell_q[0].valid ? cell_q[0].value : '0;

  // ---- handshake ----
  assign out_load    = pending_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pending_r || out_load;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // ---- command decode ----
  always_comb begin
    op        = OP_HOLD;
    status_c  = ST_DONE;
    popped_c  = '0;
    count_nxt = count_r;
    if (accept) begin
      unique case (act_t'(in_ch.action)) inside
        ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
          if (full) begin
            status_c = ST_FULL;
          end else begin
            op        = (act_t'(in_ch.action) == ACT_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                 : OP_PUSH_REAR;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            status_c = ST_EMPTY;
          end else begin
            op        = OP_POP_FRONT;
            popped_c  = cell_q[0].value;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ACT_POP_REAR: begin
          if (empty) begin
            status_c = ST_EMPTY;
          end else begin
            op        = OP_POP_REAR;
            popped_c  = rear_word;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept)        pending_r <= 1'b1;
      else if (out_load) pending_r <= 1'b0;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= status_c;
      pend_popped_r <= popped_c;
    end
    if (out_load) begin
      // cells and count already hold the state after the pending item
      out_status_r <= pend_status_r;
      out_popped_r <= pend_popped_r;
      out_count_r  <= count_r;
      out_front_r  <= front_word;
      out_rear_r   <= rear_word;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.count        = out_count_r;
  assign out_ch.front_value  = out_front_r;
  assign out_ch.rear_value   = out_rear_r;

endmodule
